// ----- design/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point ALU
// Opcodes, data and magnitude widths, and the result flag record.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned OP_W   = 4;
  localparam int unsigned DATA_W = 32;
  // magnitudes of a 32-bit signed value need up to 32 bits
  localparam int unsigned MAG_W  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_LT      = 4'd4,
    OP_GT      = 4'd5,
    OP_LE      = 4'd6,
    OP_GE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } op_t;

  // result flags carried next to the value
  typedef struct packed {
    logic compare_true;
    logic divide_by_zero;
    logic overflow;
  } flags_t;

endpackage

// ----- design/fpa_div_cell.sv -----
// ----------------------------------------------------------------------------
// fpa_div_cell: one restoring-division step of the divider row
// Shifts one dividend bit into the partial remainder, trial-subtracts the
// divisor and records one quotient bit. Side data rides along unchanged.
// ----------------------------------------------------------------------------
module fpa_div_cell
  import fpa_pkg::*;
#(
  parameter int unsigned NUM_W  = 64,
  parameter int unsigned REM_W  = 33,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              stall,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [MAG_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [NUM_W-1:0]  num_o,
  output logic [REM_W-1:0]  rem_o,
  output logic [MAG_W-1:0]  den_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_r;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [MAG_W-1:0]  den_r;
  logic [SIDE_W-1:0] side_r;
  logic [REM_W:0]    shifted;
  logic [REM_W:0]    diff;

  // shift in the next dividend bit, trial subtract, take quotient bit
  always_comb begin
    shifted = {rem_i, num_i[NUM_W-1]};
    diff    = shifted - {{(REM_W+1-MAG_W){1'b0}}, den_i};
    if (!diff[REM_W]) begin
      rem_nxt = diff[REM_W-1:0];
      num_nxt = {num_i[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[REM_W-1:0];
      num_nxt = {num_i[NUM_W-2:0], 1'b0};
    end
  end

  // advance on every unstalled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!stall) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      num_r  <= num_nxt;
      rem_r  <= rem_nxt;
      den_r  <= den_i;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign num_o  = num_r;
  assign rem_o  = rem_r;
  assign den_o  = den_r;
  assign side_o = side_r;

endmodule

// ----- design/fixed_point_alu_core.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_core: pipelined signed fixed-point ALU
// Add, subtract, multiply, divide, compare, min/max, inc/dec and integer
// conversion on 32-bit raw values with FRAC_BITS fraction bits, saturating.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid in_ready in_op in_operand_a in_operand_b | request in
//  out     | out_valid out_ready out_value out_compare_true   | result out
//          | out_divide_by_zero out_overflow                  |
//
//  One request enters per cycle while in_ready is high. Every operation passes
//  through two front stages, the row of restoring-division cells (one
//  quotient bit per cell) and the output register. Multiply uses one 32x32
//  product register ahead of the row.
//  The whole pipeline advances when the output register is empty or taken;
//  out_ready low while out_valid is high freezes it and drops in_ready. Reset clears valid bits only.
// ----------------------------------------------------------------------------
module fixed_point_alu_core
  import fpa_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_op,
  input  logic signed [DATA_W-1:0] in_operand_a,
  input  logic signed [DATA_W-1:0] in_operand_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_compare_true,
  output logic                     out_divide_by_zero,
  output logic                     out_overflow
);

  // quotient bits: enough for the widest dividend, a shifted by FRAC_BITS
  localparam int unsigned NUM_W = MAG_W + FRAC_BITS;
  localparam int unsigned REM_W = MAG_W + 1;
  localparam int unsigned SIDE_W = 1 + 1 + 3 + DATA_W;
  localparam int unsigned PROD_W = 2 * MAG_W;

  logic stall;
  logic vld_s0_r, vld_s1_r, out_vld_r;

  assign stall    = out_vld_r && !out_ready;
  assign in_ready = !stall;

  // ---------------- stage 0: decode, magnitudes, simple ops ----------------
  logic [MAG_W-1:0] mag_a, mag_b;
  logic             neg_q;
  logic [DATA_W:0]  sum_w, dif_w, inc_w, dec_w;
  logic signed [DATA_W:0] ext_a, ext_b;
  logic signed [DATA_W-1:0] simple_v;
  logic             simple_ovf, cmp_res, lt_ab, eq_ab;
  logic [MAG_W+FRAC_BITS-1:0] fi_mag;
  logic [MAG_W-1:0] ti_mag;
  op_t              op_in;

  assign op_in = op_t'(in_op);
  assign mag_a = in_operand_a[DATA_W-1] ? MAG_W'(-in_operand_a) : MAG_W'(in_operand_a);
  assign mag_b = in_operand_b[DATA_W-1] ? MAG_W'(-in_operand_b) : MAG_W'(in_operand_b);
  assign neg_q = in_operand_a[DATA_W-1] ^ in_operand_b[DATA_W-1];
  assign ext_a = {in_operand_a[DATA_W-1], in_operand_a};
  assign ext_b = {in_operand_b[DATA_W-1], in_operand_b};
  assign sum_w = ext_a + ext_b;
  assign dif_w = ext_a - ext_b;
  assign inc_w = ext_a + (DATA_W+1)'(1);
  assign dec_w = ext_a - (DATA_W+1)'(1);
  assign lt_ab = in_operand_a < in_operand_b;
  assign eq_ab = in_operand_a == in_operand_b;
  assign fi_mag = {{FRAC_BITS{1'b0}}, mag_a} << FRAC_BITS;
  // ceil of magnitude / 2^F for negatives equals floor shift of the value
  assign ti_mag = MAG_W'(in_operand_a >>> FRAC_BITS);

  function automatic logic [DATA_W:0] sat_fn(input logic [DATA_W:0] w);
    logic [DATA_W:0] r;
    r = w;
    if (w[DATA_W] != w[DATA_W-1])
      r = w[DATA_W] ? {1'b1, 1'b1, {(DATA_W-1){1'b0}}}
                    : {1'b0, 1'b0, {(DATA_W-1){1'b1}}};
    return r;
  endfunction

  always_comb begin
    simple_v   = '0;
    simple_ovf = 1'b0;
    cmp_res    = 1'b0;
    case (op_in)
      OP_ADD: begin
        simple_v = DATA_W'(sat_fn(sum_w));
        simple_ovf = sum_w[DATA_W] != sum_w[DATA_W-1];
      end
      OP_SUB: begin
        simple_v = DATA_W'(sat_fn(dif_w));
        simple_ovf = dif_w[DATA_W] != dif_w[DATA_W-1];
      end
      OP_INC: begin
        simple_v = DATA_W'(sat_fn(inc_w));
        simple_ovf = inc_w[DATA_W] != inc_w[DATA_W-1];
      end
      OP_DEC: begin
        simple_v = DATA_W'(sat_fn(dec_w));
        simple_ovf = dec_w[DATA_W] != dec_w[DATA_W-1];
      end
      OP_LT:  cmp_res = lt_ab;
      OP_GT:  cmp_res = !lt_ab && !eq_ab;
      OP_LE:  cmp_res = lt_ab || eq_ab;
      OP_GE:  cmp_res = !lt_ab;
      OP_EQ:  cmp_res = eq_ab;
      OP_NE:  cmp_res = !eq_ab;
      OP_MIN: simple_v = lt_ab ? in_operand_a : in_operand_b;
      OP_MAX: simple_v = lt_ab ? in_operand_b : in_operand_a;
      OP_TOINT: simple_v = DATA_W'(ti_mag);
      OP_FROMINT: begin
        if (in_operand_a[DATA_W-1]) begin
          simple_ovf = fi_mag > {{FRAC_BITS{1'b0}}, 1'b1, {(MAG_W-1){1'b0}}};
          simple_v = simple_ovf ? {1'b1, {(DATA_W-1){1'b0}}} : DATA_W'(-fi_mag);
        end else begin
          simple_ovf = fi_mag > {{FRAC_BITS{1'b0}}, 1'b0, {(MAG_W-1){1'b1}}};
          simple_v = simple_ovf ? {1'b0, {(DATA_W-1){1'b1}}} : DATA_W'(fi_mag);
        end
      end
      default: begin
        simple_v = '0;
      end
    endcase
  end

  // stage 0 registers
  logic [1:0]        kind_s0_r;   // 0 simple, 1 mul, 2 div, 3 div by zero
  logic              neg_s0_r;
  logic [MAG_W-1:0]  ma_s0_r, mb_s0_r;
  logic signed [DATA_W-1:0] sv_s0_r;
  flags_t            fl_s0_r;
  localparam logic [1:0] K_SIMPLE = 2'd0, K_MUL = 2'd1, K_DIV = 2'd2, K_DBZ = 2'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s0_r <= 1'b0;
    end else if (!stall) begin
      vld_s0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      neg_s0_r <= neg_q;
      ma_s0_r  <= mag_a;
      mb_s0_r  <= mag_b;
      sv_s0_r  <= simple_v;
      fl_s0_r  <= '{compare_true: cmp_res, divide_by_zero: 1'b0, overflow: simple_ovf};
      if (op_in == OP_MUL) kind_s0_r <= K_MUL;
      else if (op_in == OP_DIV) kind_s0_r <= (mag_b == '0) ? K_DBZ : K_DIV;
      else kind_s0_r <= K_SIMPLE;
    end
  end

  // ---------------- stage 1: product register, dividend setup -------------
  logic [PROD_W-1:0] prod_s1_r;
  logic [1:0]        kind_s1_r;
  logic              neg_s1_r;
  logic [MAG_W-1:0]  ma_s1_r, mb_s1_r;
  logic signed [DATA_W-1:0] sv_s1_r;
  flags_t            fl_s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r <= 1'b0;
    end else if (!stall) begin
      vld_s1_r <= vld_s0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      prod_s1_r <= ma_s0_r * mb_s0_r;
      kind_s1_r <= kind_s0_r;
      neg_s1_r  <= neg_s0_r;
      ma_s1_r   <= ma_s0_r;
      mb_s1_r   <= mb_s0_r;
      sv_s1_r   <= sv_s0_r;
      fl_s1_r   <= fl_s0_r;
    end
  end

  // multiply: round(p / 2^F) here rather than in the row, since the product
  // is wider than the row's dividend; the row carries the result as side data
  logic [PROD_W:0]   prod_rnd;
  logic [PROD_W-FRAC_BITS:0] mul_q;
  logic              mul_ovf;
  logic signed [DATA_W-1:0] mul_v;
  assign prod_rnd = {1'b0, prod_s1_r} + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
  assign mul_q    = prod_rnd[PROD_W:FRAC_BITS];

  always_comb begin
    if (neg_s1_r) begin
      mul_ovf = mul_q > (PROD_W-FRAC_BITS+1)'(64'h8000_0000);
      mul_v   = mul_ovf ? {1'b1, {(DATA_W-1){1'b0}}} : DATA_W'(-mul_q);
    end else begin
      mul_ovf = mul_q > (PROD_W-FRAC_BITS+1)'(64'h7FFF_FFFF);
      mul_v   = mul_ovf ? {1'b0, {(DATA_W-1){1'b1}}} : DATA_W'(mul_q);
    end
  end

  // side data into the row: kind (is div), neg, flags, settled value
  logic [SIDE_W-1:0] side_in;
  logic signed [DATA_W-1:0] pre_v;
  flags_t            pre_fl;
  always_comb begin
    pre_v  = sv_s1_r;
    pre_fl = fl_s1_r;
    case (kind_s1_r)
      K_MUL: begin
        pre_v = mul_v;
        pre_fl.overflow = mul_ovf;
      end
      K_DBZ: begin
        pre_v = '0;
        pre_fl.divide_by_zero = 1'b1;
      end
      default: begin
        pre_v = sv_s1_r;
      end
    endcase
  end
  assign side_in = {kind_s1_r == K_DIV, neg_s1_r, pre_fl, pre_v};

  // ---------------- row of division cells ----------------
  logic              c_vld  [NUM_W+1];
  logic [NUM_W-1:0]  c_num  [NUM_W+1];
  logic [REM_W-1:0]  c_rem  [NUM_W+1];
  logic [MAG_W-1:0]  c_den  [NUM_W+1];
  logic [SIDE_W-1:0] c_side [NUM_W+1];

  assign c_vld[0]  = vld_s1_r;
  assign c_num[0]  = {ma_s1_r, {FRAC_BITS{1'b0}}};
  assign c_rem[0]  = '0;
  assign c_den[0]  = mb_s1_r;
  assign c_side[0] = side_in;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fpa_div_cell #(
      .NUM_W (NUM_W),
      .REM_W (REM_W),
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .stall (stall),
      .vld_i (c_vld[i]),
      .num_i (c_num[i]),
      .rem_i (c_rem[i]),
      .den_i (c_den[i]),
      .side_i(c_side[i]),
      .vld_o (c_vld[i+1]),
      .num_o (c_num[i+1]),
      .rem_o (c_rem[i+1]),
      .den_o (c_den[i+1]),
      .side_o(c_side[i+1])
    );
  end

  // ---------------- final stage: round quotient, saturate ----------------
  logic [NUM_W-1:0]  quo;
  logic [REM_W-1:0]  rem_f;
  logic [MAG_W-1:0]  den_f;
  logic [REM_W:0]    rem2;
  logic [NUM_W:0]    quo_r;
  logic              div_sel, div_neg, div_ovf;
  flags_t            side_fl;
  logic signed [DATA_W-1:0] side_v, div_v, fin_v;
  flags_t            fin_fl;

  assign quo   = c_num[NUM_W];
  assign rem_f = c_rem[NUM_W];
  assign den_f = c_den[NUM_W];
  assign {div_sel, div_neg, side_fl, side_v} = c_side[NUM_W];
  // round half up: add one when 2*rem >= den
  assign rem2  = {rem_f, 1'b0};
  assign quo_r = {1'b0, quo} +
                 (NUM_W+1)'(rem2 >= {{(REM_W+1-MAG_W){1'b0}}, den_f});

  always_comb begin
    if (div_neg) begin
      div_ovf = quo_r > (NUM_W+1)'(64'h8000_0000);
      div_v   = div_ovf ? {1'b1, {(DATA_W-1){1'b0}}} : DATA_W'(-quo_r);
    end else begin
      div_ovf = quo_r > (NUM_W+1)'(64'h7FFF_FFFF);
      div_v   = div_ovf ? {1'b0, {(DATA_W-1){1'b1}}} : DATA_W'(quo_r);
    end
    fin_v  = side_v;
    fin_fl = side_fl;
    if (div_sel) begin
      fin_v = div_v;
      fin_fl.overflow = div_ovf;
    end
  end

  // output register: load on advance, hold while stalled
  logic signed [DATA_W-1:0] out_v_r;
  flags_t                   out_fl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!stall) begin
      out_vld_r <= c_vld[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      out_v_r  <= fin_v;
      out_fl_r <= fin_fl;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_value          = out_v_r;
  assign out_compare_true   = out_fl_r.compare_true;
  assign out_divide_by_zero = out_fl_r.divide_by_zero;
  assign out_overflow       = out_fl_r.overflow;

  // ---------------- assertions ----------------
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(out_v_r) && out_vld_r)
    else $error("output changed while stalled");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input blocked with empty output");

  a_dbz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_fl_r.divide_by_zero |-> !out_fl_r.overflow && out_v_r == '0)
    else $error("divide by zero result malformed");

  a_cmp_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_fl_r.compare_true |-> out_v_r == '0 && !out_fl_r.overflow)
    else $error("compare result carries a value");

endmodule
